[design/aclfu_pkg.sv]
// Package for the fully associative LFU write-through cache.
// Holds the fixed field widths, the statistics indexes and the store control type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aclfu_pkg;

    // Fixed widths of the request and result fields.
    localparam int ADDR_W      = 7;
    localparam int DATA_W      = 8;
    localparam int STAT_W      = 32;
    localparam int FRAME_OUT_W = 3;
    localparam int TAG_OUT_W   = 5;
    localparam int OFF_OUT_W   = 2;
    localparam int ADDR_SPAN   = 1 << ADDR_W;

    // Statistics counter indexes: {write, miss}.
    localparam logic [1:0] STAT_READ_HIT   = 2'd0;
    localparam logic [1:0] STAT_READ_MISS  = 2'd1;
    localparam logic [1:0] STAT_WRITE_HIT  = 2'd2;
    localparam logic [1:0] STAT_WRITE_MISS = 2'd3;

    // Enables from the sequencer to the data store.
    typedef struct packed {
        logic mem_we;         // write the backing memory
        logic frame_we;       // write the frame memory
        logic frame_re;       // read the frame memory
        logic frame_src_mem;  // frame write data comes from the backing memory
    } store_ctrl_t;

endpackage

`default_nettype wire

[design/aclfu_store.sv]
// Data store of the cache: the backing memory and the frame memory.
// Runs the zero-fill sweep after reset. Depends on aclfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aclfu_store #(
    parameter int FRAMES          = 8,
    parameter int WORDS_PER_BLOCK = 4,
    parameter int MEM_BLOCKS      = 32
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire aclfu_pkg::store_ctrl_t               ctrl,
    input  wire logic [$clog2(MEM_BLOCKS*WORDS_PER_BLOCK)-1:0] mem_addr,
    input  wire logic [$clog2(FRAMES*WORDS_PER_BLOCK)-1:0]     frame_addr,
    input  wire logic [aclfu_pkg::DATA_W-1:0]         wdata,
    output logic      [aclfu_pkg::DATA_W-1:0]         frame_rdata,
    output logic                                      busy
);
    import aclfu_pkg::*;

    localparam int MEM_DEPTH   = MEM_BLOCKS * WORDS_PER_BLOCK;
    localparam int FRAME_DEPTH = FRAMES * WORDS_PER_BLOCK;
    localparam int MADDR_W     = $clog2(MEM_DEPTH);
    localparam int FADDR_W     = $clog2(FRAME_DEPTH);
    localparam int CLR_N       = (MEM_DEPTH > FRAME_DEPTH) ? MEM_DEPTH : FRAME_DEPTH;
    localparam int CLR_W       = $clog2(CLR_N);

    logic [DATA_W-1:0] mem_array   [MEM_DEPTH];
    logic [DATA_W-1:0] frame_array [FRAME_DEPTH];

    logic [CLR_W-1:0]  clr_idx_reg, clr_idx_next;
    logic              busy_reg, busy_next;
    logic [DATA_W-1:0] mem_rdata_reg;
    logic [DATA_W-1:0] frame_rdata_reg;

    logic              clr_mem_en;
    logic              clr_frame_en;
    logic [DATA_W-1:0] frame_wdata;

    // Sweep counter: one entry of each memory per cycle after reset.
    always_comb begin
        clr_idx_next = clr_idx_reg;
        busy_next    = busy_reg;
        if (busy_reg) begin
            if (clr_idx_reg == CLR_W'(CLR_N - 1)) begin
                busy_next = 1'b0;
            end else begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    assign clr_mem_en   = busy_reg && ({1'b0, clr_idx_reg} < (CLR_W + 1)'(MEM_DEPTH));
    assign clr_frame_en = busy_reg && ({1'b0, clr_idx_reg} < (CLR_W + 1)'(FRAME_DEPTH));
    assign frame_wdata  = ctrl.frame_src_mem ? mem_rdata_reg : wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end else begin
            clr_idx_reg <= clr_idx_next;
            busy_reg    <= busy_next;
        end
    end

    // Backing memory: one port, registered read.
    always_ff @(posedge aclk) begin
        if (clr_mem_en) begin
            mem_array[clr_idx_reg[MADDR_W-1:0]] <= '0;
        end else if (ctrl.mem_we) begin
            mem_array[mem_addr] <= wdata;
        end
        mem_rdata_reg <= mem_array[mem_addr];
    end

    // Frame memory: one port, registered read on request.
    always_ff @(posedge aclk) begin
        if (clr_frame_en) begin
            frame_array[clr_idx_reg[FADDR_W-1:0]] <= '0;
        end else if (ctrl.frame_we) begin
            frame_array[frame_addr] <= frame_wdata;
        end
        if (ctrl.frame_re) begin
            frame_rdata_reg <= frame_array[frame_addr];
        end
    end

    assign frame_rdata = frame_rdata_reg;
    assign busy        = busy_reg;

endmodule

`default_nettype wire

[design/assoc_cache_lfu_write_through.sv]
// Top level of the fully associative LFU write-through cache with its own backing memory.
// Depends on aclfu_pkg and aclfu_store.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative cache of FRAMES frames of WORDS_PER_BLOCK bytes, in front of a backing
// memory of MEM_BLOCKS blocks. Each request reads or writes one byte; writes go through to
// the backing memory and allocate on a miss. A miss refills the frame with the lowest use
// count (lowest index on a tie). One request is handled at a time by a sequencer that walks
// the frames with a single tag and count comparator. A hit on frame k takes k + 1 scan steps,
// one access step, a result step (which waits until the output is free) and an idle step
// before the next acceptance; a miss scans all frames, then refills the block one byte at a
// time, each byte read through the single backing memory port and then written to the frame,
// before its access, result and idle steps. After reset the block zero-fills its memories
// before it takes its first request. The statistics outputs show the counts with the current
// result included.
module assoc_cache_lfu_write_through #(
    parameter int FRAMES          = 8,
    parameter int WORDS_PER_BLOCK = 4,
    parameter int MEM_BLOCKS      = 32,
    parameter int COUNT_WIDTH     = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [aclfu_pkg::ADDR_W-1:0]    s_address,
    input  wire logic [aclfu_pkg::DATA_W-1:0]    s_write_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_hit,
    output logic [aclfu_pkg::FRAME_OUT_W-1:0]    m_frame,
    output logic [aclfu_pkg::TAG_OUT_W-1:0]      m_tag_out,
    output logic [aclfu_pkg::OFF_OUT_W-1:0]      m_offset_out,
    output logic [aclfu_pkg::DATA_W-1:0]         m_read_data,
    output logic [aclfu_pkg::STAT_W-1:0]         m_read_hits,
    output logic [aclfu_pkg::STAT_W-1:0]         m_read_misses,
    output logic [aclfu_pkg::STAT_W-1:0]         m_write_hits,
    output logic [aclfu_pkg::STAT_W-1:0]         m_write_misses
);
    import aclfu_pkg::*;

    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int TAG_W   = $clog2(MEM_BLOCKS);
    localparam int OFF_W   = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
    localparam int MADDR_W = $clog2(MEM_BLOCKS * WORDS_PER_BLOCK);
    localparam int FADDR_W = $clog2(FRAMES * WORDS_PER_BLOCK);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_ACCESS,
        ST_DONE
    } state_t;

    // Address split tables and reset tags, worked out at elaboration.
    logic [TAG_W-1:0] tag_lut  [ADDR_SPAN];
    logic [OFF_W-1:0] off_lut  [ADDR_SPAN];
    logic [TAG_W-1:0] tag_init [FRAMES];

    for (genvar a = 0; a < ADDR_SPAN; a++) begin : g_split
        localparam int TagVal = (a / WORDS_PER_BLOCK) % MEM_BLOCKS;
        localparam int OffVal = a % WORDS_PER_BLOCK;
        assign tag_lut[a] = TAG_W'(TagVal);
        assign off_lut[a] = OFF_W'(OffVal);
    end

    for (genvar f = 0; f < FRAMES; f++) begin : g_tag_init
        localparam int InitVal = f % MEM_BLOCKS;
        assign tag_init[f] = TAG_W'(InitVal);
    end

    state_t                 state_reg;
    logic [TAG_W-1:0]       frame_tag_reg [FRAMES];
    logic [COUNT_WIDTH-1:0] use_cnt_reg   [FRAMES];
    logic [STAT_W-1:0]      stat_reg      [4];

    logic                   is_write_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [OFF_W-1:0]       off_reg;
    logic [DATA_W-1:0]      wdata_reg;
    logic [FRAME_W-1:0]     scan_idx_reg;
    logic [FRAME_W-1:0]     best_idx_reg;
    logic [COUNT_WIDTH-1:0] best_cnt_reg;
    logic [FRAME_W-1:0]     sel_frame_reg;
    logic                   hit_reg;
    logic [OFF_W-1:0]       fill_cnt_reg;

    logic                   m_valid_reg;
    logic                   m_hit_reg;
    logic [FRAME_W-1:0]     m_frame_reg;
    logic [TAG_W-1:0]       m_tag_reg;
    logic [OFF_W-1:0]       m_off_reg;
    logic [DATA_W-1:0]      m_data_reg;

    store_ctrl_t            st_ctrl;
    logic [MADDR_W-1:0]     mem_addr;
    logic [FADDR_W-1:0]     frame_addr;
    logic [DATA_W-1:0]      frame_rdata;
    logic                   store_busy;

    logic                   accept;
    logic                   out_free;
    logic                   scan_match;
    logic                   scan_less;
    logic                   scan_last;
    logic [COUNT_WIDTH-1:0] scan_cnt;
    logic [OFF_W-1:0]       mem_word;
    logic [OFF_W-1:0]       frame_word;
    logic [1:0]             stat_sel;

    assign s_ready  = (state_reg == ST_IDLE) && !store_busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Shared comparator: one frame's tag and use count per scan step.
    assign scan_cnt   = use_cnt_reg[scan_idx_reg];
    assign scan_match = (frame_tag_reg[scan_idx_reg] == tag_reg);
    assign scan_less  = (scan_cnt < best_cnt_reg);
    assign scan_last  = (scan_idx_reg == FRAME_W'(FRAMES - 1));

    // Store addresses: the refill walks the block, an access uses the offset.
    assign mem_word   = (state_reg == ST_FILL_RD) ? fill_cnt_reg : off_reg;
    assign frame_word = (state_reg == ST_FILL_WR) ? fill_cnt_reg : off_reg;
    assign mem_addr   = MADDR_W'(tag_reg) * MADDR_W'(WORDS_PER_BLOCK) + MADDR_W'(mem_word);
    assign frame_addr = FADDR_W'(sel_frame_reg) * FADDR_W'(WORDS_PER_BLOCK)
                      + FADDR_W'(frame_word);

    always_comb begin
        st_ctrl.mem_we        = (state_reg == ST_ACCESS) && is_write_reg;
        st_ctrl.frame_we      = (state_reg == ST_FILL_WR)
                             || ((state_reg == ST_ACCESS) && is_write_reg);
        st_ctrl.frame_re      = (state_reg == ST_ACCESS) && !is_write_reg;
        st_ctrl.frame_src_mem = (state_reg == ST_FILL_WR);
    end

    assign stat_sel = {is_write_reg, !hit_reg};

    aclfu_store #(
        .FRAMES          (FRAMES),
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
        .MEM_BLOCKS      (MEM_BLOCKS)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (st_ctrl),
        .mem_addr    (mem_addr),
        .frame_addr  (frame_addr),
        .wdata       (wdata_reg),
        .frame_rdata (frame_rdata),
        .busy        (store_busy)
    );

    // Sequencer: scan, refill, access and result, with the frame state it updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                frame_tag_reg[i] <= tag_init[i];
                use_cnt_reg[i]   <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                stat_reg[i] <= '0;
            end
        end else begin
            // The result state reloads the output itself when the old result leaves.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        is_write_reg <= s_mode;
                        tag_reg      <= tag_lut[s_address];
                        off_reg      <= off_lut[s_address];
                        wdata_reg    <= s_write_data;
                        scan_idx_reg <= '0;
                        best_idx_reg <= '0;
                        best_cnt_reg <= use_cnt_reg[0];
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    priority if (scan_match) begin
                        // Lowest matching frame serves the request.
                        hit_reg       <= 1'b1;
                        sel_frame_reg <= scan_idx_reg;
                        if (scan_cnt != '1) begin
                            use_cnt_reg[scan_idx_reg] <= scan_cnt + 1'b1;
                        end
                        state_reg <= ST_ACCESS;
                    end else if (scan_last) begin
                        // Miss: victim is the least used frame seen.
                        hit_reg       <= 1'b0;
                        sel_frame_reg <= scan_less ? scan_idx_reg : best_idx_reg;
                        fill_cnt_reg  <= '0;
                        state_reg     <= ST_FILL_RD;
                    end else begin
                        if (scan_less) begin
                            best_idx_reg <= scan_idx_reg;
                            best_cnt_reg <= scan_cnt;
                        end
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_FILL_RD: begin
                    state_reg <= ST_FILL_WR;
                end
                ST_FILL_WR: begin
                    if (fill_cnt_reg == OFF_W'(WORDS_PER_BLOCK - 1)) begin
                        frame_tag_reg[sel_frame_reg] <= tag_reg;
                        use_cnt_reg[sel_frame_reg]   <= COUNT_WIDTH'(1);
                        state_reg                    <= ST_ACCESS;
                    end else begin
                        fill_cnt_reg <= fill_cnt_reg + 1'b1;
                        state_reg    <= ST_FILL_RD;
                    end
                end
                ST_ACCESS: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_hit_reg   <= hit_reg;
                        m_frame_reg <= sel_frame_reg;
                        m_tag_reg   <= tag_reg;
                        m_off_reg   <= off_reg;
                        m_data_reg  <= is_write_reg ? wdata_reg : frame_rdata;
                        if (stat_reg[stat_sel] != '1) begin
                            stat_reg[stat_sel] <= stat_reg[stat_sel] + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result ports; statistics change only when a new result is loaded.
    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_frame        = FRAME_OUT_W'(m_frame_reg);
    assign m_tag_out      = TAG_OUT_W'(m_tag_reg);
    assign m_offset_out   = OFF_OUT_W'(m_off_reg);
    assign m_read_data    = m_data_reg;
    assign m_read_hits    = stat_reg[STAT_READ_HIT];
    assign m_read_misses  = stat_reg[STAT_READ_MISS];
    assign m_write_hits   = stat_reg[STAT_WRITE_HIT];
    assign m_write_misses = stat_reg[STAT_WRITE_MISS];

endmodule

`default_nettype wire
